### rtl/core/vvpi_pkg.sv
// shared types and constants of the velocity verlet particle integrator
// no dependencies
package vvpi_pkg;

    localparam int WORD_W = 32;
    localparam int DT_W   = 16;
    localparam int BOX_W  = 31;
    localparam int CMD_W  = 3;
    localparam int PIDX_W = 10;
    localparam int DIV_W  = 48;
    localparam int DCNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_LOAD_POS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_VEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DRIFT    = 3'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_MASS = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    localparam logic CFG_TIME_STEP = 1'b0;
    localparam logic CFG_BOX_SIZE  = 1'b1;

    localparam logic [DT_W-1:0]  TIME_STEP_RESET = 16'd655;
    localparam logic [BOX_W-1:0] BOX_SIZE_RESET  = 31'd1048576;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_READ,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_ACC,
        OP_KICK,
        OP_MUL_T,
        OP_DRIFT,
        OP_WRITE,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic div_done;
        logic force_div;
    } dp_status_t;

endpackage

### rtl/core/vvpi_ctrl.sv
// integrator sequencer: per axis read, divide if force, kick, drift, write
// depends on vvpi_pkg
module vvpi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  vvpi_pkg::dp_status_t status_in,
    output vvpi_pkg::dp_cmd_t   cmd_out,
    output logic                busy
);
    import vvpi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_DIV_INIT,
        S_DIV,
        S_MUL1,
        S_KICK,
        S_MUL2,
        S_DRIFT,
        S_WRITE,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_REDUCE;
                    axis_next  = 2'd0;
                end
            end
            S_REDUCE:
            begin
                if (status_in.reduce_done)
                    state_next = S_READ;
            end
            S_READ:     state_next = status_in.force_div ? S_DIV_INIT : S_MUL1;
            S_DIV_INIT: state_next = S_DIV;
            S_DIV:
            begin
                if (status_in.div_done)
                    state_next = S_MUL1;
            end
            S_MUL1:     state_next = S_KICK;
            S_KICK:     state_next = S_MUL2;
            S_MUL2:     state_next = S_DRIFT;
            S_DRIFT:    state_next = S_WRITE;
            S_WRITE:
            begin
                if (axis_reg == 2'd2)
                    state_next = S_DONE;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_READ;
                end
            end
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_out.axis = axis_reg;
        case (state_reg)
            S_IDLE:     cmd_out.op = start ? OP_LOAD : OP_NONE;
            S_REDUCE:   cmd_out.op = OP_REDUCE;
            S_READ:     cmd_out.op = OP_READ;
            S_DIV_INIT: cmd_out.op = OP_DIV_INIT;
            S_DIV:      cmd_out.op = OP_DIV_STEP;
            S_MUL1:     cmd_out.op = OP_MUL_ACC;
            S_KICK:     cmd_out.op = OP_KICK;
            S_MUL2:     cmd_out.op = OP_MUL_T;
            S_DRIFT:    cmd_out.op = OP_DRIFT;
            S_WRITE:    cmd_out.op = OP_WRITE;
            S_DONE:     cmd_out.op = OP_DONE;
            default:    cmd_out.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

### rtl/core/vvpi_datapath.sv
// datapath of the integrator: particle stores, divider, multiplier chain, wrap
// depends on vvpi_pkg
module vvpi_datapath #(
    parameter int PARTICLE_COUNT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vvpi_pkg::dp_cmd_t               cmd_in,
    output vvpi_pkg::dp_status_t            status_out,
    input  logic                            cfg_we,
    input  logic                            cfg_sel,
    input  logic [vvpi_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic [vvpi_pkg::CMD_W-1:0]      in_cmd,
    input  logic [vvpi_pkg::PIDX_W-1:0]     in_index,
    input  logic signed [vvpi_pkg::WORD_W-1:0] in_x,
    input  logic signed [vvpi_pkg::WORD_W-1:0] in_y,
    input  logic signed [vvpi_pkg::WORD_W-1:0] in_z,
    input  logic [vvpi_pkg::WORD_W-1:0]     in_mass,
    output logic                            res_valid,
    output logic signed [vvpi_pkg::WORD_W-1:0] res_pos [3],
    output logic signed [vvpi_pkg::WORD_W-1:0] res_vel [3],
    output logic [1:0]                      res_status
);
    import vvpi_pkg::*;

    localparam int IDX_W     = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
    localparam int ADDR_W    = IDX_W + 2;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic [DT_W-1:0]  time_step_reg;
    logic [BOX_W-1:0] box_size_reg;

    logic [CMD_W-1:0]         cmd_reg;
    logic [PIDX_W-1:0]        idx_reg;
    logic signed [WORD_W-1:0] val_reg [3];
    logic [WORD_W-1:0]        mass_reg;
    logic                     flag_reg;

    logic signed [WORD_W-1:0] pos_mem [MEM_DEPTH];
    logic signed [WORD_W-1:0] vel_mem [MEM_DEPTH];
    logic signed [WORD_W-1:0] acc_mem [MEM_DEPTH];
    logic signed [WORD_W-1:0] pos_q, vel_q, acc_q;

    logic [WORD_W:0]  div_rem_reg;
    logic [DIV_W-1:0] div_quo_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic             div_neg_reg;

    logic signed [WORD_W-1:0] acc_use_reg;
    logic signed [48:0]       prod1_reg;
    logic signed [WORD_W-1:0] vel_new_reg;
    logic                     vel_sat_reg;
    logic signed [33:0]       t_reg;
    logic signed [50:0]       prod2_reg;
    logic signed [WORD_W-1:0] pos_new_reg;
    logic                     pos_sat_reg;

    logic [ADDR_W-1:0]        addr;
    logic                     force_div;
    logic signed [WORD_W-1:0] val_cur;
    logic [WORD_W:0]          mag;
    logic [WORD_W:0]          rem_sh;
    logic                     rem_ge;
    logic signed [WORD_W-1:0] acc_div;
    logic                     acc_sat;
    logic signed [WORD_W-1:0] acc_use;
    logic signed [DT_W:0]     dt_s;
    logic signed [48:0]       prod1;
    logic signed [32:0]       kick;
    logic signed [33:0]       vel_sum;
    logic signed [WORD_W-1:0] vel_sat_val;
    logic                     vel_sat;
    logic signed [50:0]       prod2;
    logic signed [37:0]       step, p, p2, box_s, pw;
    logic signed [WORD_W-1:0] pos_sat_val;
    logic                     pos_sat;
    logic                     we;
    logic signed [WORD_W-1:0] pos_wdata, vel_wdata, acc_wdata;
    logic                     pos_we, vel_we, acc_we;
    logic signed [WORD_W-1:0] out_pos, out_vel;
    logic                     out_flag;

    assign addr      = {IDX_W'(idx_reg), cmd_in.axis};
    assign force_div = (cmd_reg == CMD_FORCE) && (mass_reg != '0);
    assign val_cur   = val_reg[cmd_in.axis];
    assign mag       = val_cur[WORD_W-1] ? (WORD_W+1)'(-(WORD_W+1)'(val_cur))
                                         : (WORD_W+1)'(val_cur);

    assign status_out.reduce_done = ({7'd0, idx_reg} < 17'(PARTICLE_COUNT));
    assign status_out.div_done    = (div_cnt_reg == DCNT_W'(1));
    assign status_out.force_div   = force_div;

    // restoring divide, one quotient bit per cycle
    assign rem_sh = {div_rem_reg[WORD_W-1:0], div_quo_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, mass_reg});

    always_comb
    begin
        acc_sat = 1'b0;
        if (!div_neg_reg)
        begin
            if (div_quo_reg > DIV_W'(WMAX))
            begin
                acc_div = WMAX;
                acc_sat = 1'b1;
            end
            else
                acc_div = WORD_W'(div_quo_reg);
        end
        else
        begin
            if (div_quo_reg > DIV_W'({1'b1, {(WORD_W-1){1'b0}}}))
            begin
                acc_div = WMIN;
                acc_sat = 1'b1;
            end
            else
                acc_div = WORD_W'(-div_quo_reg);
        end
    end

    assign acc_use = force_div ? acc_div : acc_q;
    assign dt_s    = $signed({1'b0, time_step_reg});
    assign prod1   = acc_use * dt_s;
    assign kick    = 33'(prod1_reg >>> 17);
    assign vel_sum = 34'(vel_q) + 34'(kick);

    always_comb
    begin
        vel_sat = 1'b0;
        if (vel_sum > 34'(WMAX))
        begin
            vel_sat_val = WMAX;
            vel_sat     = 1'b1;
        end
        else if (vel_sum < 34'(WMIN))
        begin
            vel_sat_val = WMIN;
            vel_sat     = 1'b1;
        end
        else
            vel_sat_val = WORD_W'(vel_sum);
    end

    assign prod2 = t_reg * dt_s;
    assign step  = 38'(prod2_reg >>> 16);
    assign p     = 38'(pos_q) + step;
    assign p2    = p <<< 1;
    assign box_s = $signed({7'd0, box_size_reg});

    // single periodic wrap then saturate
    always_comb
    begin
        if (p2 >= box_s)
            pw = p - box_s;
        else if (p2 < -box_s)
            pw = p + box_s;
        else
            pw = p;
        pos_sat = 1'b0;
        if (pw > 38'(WMAX))
        begin
            pos_sat_val = WMAX;
            pos_sat     = 1'b1;
        end
        else if (pw < 38'(WMIN))
        begin
            pos_sat_val = WMIN;
            pos_sat     = 1'b1;
        end
        else
            pos_sat_val = WORD_W'(pw);
    end

    assign we = (cmd_in.op == OP_WRITE);

    always_comb
    begin
        pos_we    = 1'b0;
        vel_we    = 1'b0;
        acc_we    = 1'b0;
        pos_wdata = val_cur;
        vel_wdata = '0;
        acc_wdata = '0;
        out_pos   = pos_q;
        out_vel   = vel_q;
        out_flag  = 1'b0;
        case (cmd_reg)
            CMD_LOAD_POS:
            begin
                pos_we  = we;
                vel_we  = we;
                acc_we  = we;
                out_pos = val_cur;
                out_vel = '0;
            end
            CMD_LOAD_VEL:
            begin
                vel_we    = we;
                vel_wdata = val_cur;
                out_vel   = val_cur;
            end
            CMD_FORCE:
            begin
                if (force_div)
                begin
                    vel_we    = we;
                    acc_we    = we;
                    vel_wdata = vel_new_reg;
                    acc_wdata = acc_use_reg;
                    out_vel   = vel_new_reg;
                    out_flag  = vel_sat_reg;
                end
            end
            CMD_DRIFT:
            begin
                pos_we    = we;
                pos_wdata = pos_new_reg;
                out_pos   = pos_new_reg;
                out_flag  = pos_sat_reg;
            end
            default:
            begin
                out_pos = pos_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[addr] <= pos_wdata;
        if (vel_we)
            vel_mem[addr] <= vel_wdata;
        if (acc_we)
            acc_mem[addr] <= acc_wdata;
        if (cmd_in.op == OP_READ)
        begin
            pos_q <= pos_mem[addr];
            vel_q <= vel_mem[addr];
            acc_q <= acc_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
            box_size_reg  <= BOX_SIZE_RESET;
            res_valid     <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel == CFG_TIME_STEP)
                    time_step_reg <= cfg_wdata[DT_W-1:0];
                else
                    box_size_reg <= cfg_wdata[BOX_W-1:0];
            end
            res_valid <= (cmd_in.op == OP_DONE);
            if (cmd_in.op == OP_DIV_INIT)
                div_cnt_reg <= DCNT_W'(DIV_W);
            else if (cmd_in.op == OP_DIV_STEP)
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd_in.op)
            OP_LOAD:
            begin
                cmd_reg    <= in_cmd;
                idx_reg    <= in_index;
                val_reg[0] <= in_x;
                val_reg[1] <= in_y;
                val_reg[2] <= in_z;
                mass_reg   <= in_mass;
                flag_reg   <= 1'b0;
            end
            OP_REDUCE:
            begin
                if (!status_out.reduce_done)
                    idx_reg <= idx_reg - PIDX_W'(PARTICLE_COUNT);
            end
            OP_DIV_INIT:
            begin
                div_rem_reg <= '0;
                div_quo_reg <= {mag[WORD_W-1:0], 16'd0};
                div_neg_reg <= val_cur[WORD_W-1];
            end
            OP_DIV_STEP:
            begin
                div_rem_reg <= rem_ge ? (rem_sh - {1'b0, mass_reg}) : rem_sh;
                div_quo_reg <= {div_quo_reg[DIV_W-2:0], rem_ge};
            end
            OP_MUL_ACC:
            begin
                acc_use_reg <= acc_use;
                prod1_reg   <= prod1;
                if (force_div && acc_sat)
                    flag_reg <= 1'b1;
            end
            OP_KICK:
            begin
                vel_new_reg <= vel_sat_val;
                vel_sat_reg <= vel_sat;
                t_reg       <= vel_sum;
            end
            OP_MUL_T:
            begin
                prod2_reg <= prod2;
            end
            OP_DRIFT:
            begin
                pos_new_reg <= pos_sat_val;
                pos_sat_reg <= pos_sat;
            end
            OP_WRITE:
            begin
                res_pos[cmd_in.axis] <= out_pos;
                res_vel[cmd_in.axis] <= out_vel;
                if (out_flag)
                    flag_reg <= 1'b1;
            end
            OP_DONE:
            begin
                if (cmd_reg == CMD_FORCE && mass_reg == '0)
                    res_status <= ST_ZERO_MASS;
                else if (flag_reg)
                    res_status <= ST_SATURATED;
                else
                    res_status <= ST_OK;
            end
            default:
            begin
                flag_reg <= flag_reg;
            end
        endcase
    end

endmodule

### rtl/core/velocity_verlet_particle_integrator.sv
// top level of the velocity verlet particle integrator with periodic box
// depends on vvpi_pkg, vvpi_ctrl, vvpi_datapath
//
// One command per item; busy is high while it runs and done pulses for one
// cycle with the result, which must be taken then. An item first reduces
// the index modulo the particle count (once per multiple of the count in
// the index, so never when the count is 1024 or more), then works the three
// axes one by one through a single store address and two multipliers, and
// runs the bit-serial force divider on each axis for apply force with
// nonzero mass.
module velocity_verlet_particle_integrator #(
    parameter int PARTICLE_COUNT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          cmd,
    input  logic [9:0]          particle_index,
    input  logic signed [31:0]  value_x,
    input  logic signed [31:0]  value_y,
    input  logic signed [31:0]  value_z,
    input  logic [31:0]         particle_mass,
    output logic                done,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  vel_z,
    output logic [1:0]          status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import vvpi_pkg::*;

    dp_cmd_t                  dp_cmd;
    dp_status_t               dp_status;
    logic signed [WORD_W-1:0] res_pos [3];
    logic signed [WORD_W-1:0] res_vel [3];

    assign cfg_ready = 1'b1;

    vvpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .status_in (dp_status),
        .cmd_out   (dp_cmd),
        .busy      (busy)
    );

    vvpi_datapath #(
        .PARTICLE_COUNT (PARTICLE_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_in     (dp_cmd),
        .status_out (dp_status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_sel    (cfg_index),
        .cfg_wdata  (cfg_data),
        .in_cmd     (cmd),
        .in_index   (particle_index),
        .in_x       (value_x),
        .in_y       (value_y),
        .in_z       (value_z),
        .in_mass    (particle_mass),
        .res_valid  (done),
        .res_pos    (res_pos),
        .res_vel    (res_vel),
        .res_status (status)
    );

    assign pos_x = res_pos[0];
    assign pos_y = res_pos[1];
    assign pos_z = res_pos[2];
    assign vel_x = res_vel[0];
    assign vel_y = res_vel[1];
    assign vel_z = res_vel[2];

    // result comes out after the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transfer did not start work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// testbench for the velocity verlet particle integrator: directed and random commands
// checked against a behavioral predictor of the particle store; depends on vvpi_pkg
module tb;
    import vvpi_pkg::*;

    localparam logic [2:0] CMD_READ = 3'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] cmd = '0;
    logic [9:0] particle_index = '0;
    logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
    logic [31:0] particle_mass = '0;
    logic done;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [1:0] status;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [1:0]  st;
    } answer_t;

    longint pos_mem [1024][3];
    longint vel_mem [1024][3];
    longint acc_mem [1024][3];
    bit     loaded [1024];
    longint dt_q = 655;
    longint box_q = 1048576;
    answer_t answer_q[$];
    int errors = 0;

    velocity_verlet_particle_integrator u_dut (.*);

    always #5 clk = ~clk;

    function automatic longint clamp32(longint v, ref bit f);
        if (v > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic longint floor_shift(longint v, int k);
        if (v >= 0) return v >>> k;
        return -((-v + ((64'sd1 << k) - 1)) >>> k);
    endfunction

    function automatic longint scale_dt(longint v, longint dt, int k);
        longint q, r;
        q = floor_shift(v, k);
        r = v - q * (64'sd1 << k);
        return q * dt + ((r * dt) >>> k);
    endfunction

    function automatic longint force_div(longint f, longint m, ref bit flg);
        longint mag, q1, r1, q;
        mag = (f < 0) ? -f : f;
        q1 = mag / m;
        r1 = mag % m;
        if (q1 > 65536) q = 64'sd1 << 32;
        else q = (q1 << 16) + ((r1 << 16) / m);
        return clamp32((f < 0) ? -q : q, flg);
    endfunction

    function automatic answer_t integrate(logic [2:0] c, int idx, longint v[3], longint m);
        answer_t r;
        bit flg;
        logic [1:0] st;
        longint a, h, p;
        flg = 0;
        st = ST_OK;
        if (c == CMD_LOAD_POS) begin
            for (int i = 0; i < 3; i++)
            begin
                pos_mem[idx][i] = clamp32(v[i], flg);
                vel_mem[idx][i] = 0;
                acc_mem[idx][i] = 0;
            end
        end
        else if (c == CMD_LOAD_VEL) begin
            for (int i = 0; i < 3; i++) vel_mem[idx][i] = clamp32(v[i], flg);
        end
        else if (c == CMD_FORCE) begin
            if (m == 0) st = ST_ZERO_MASS;
            else begin
                for (int i = 0; i < 3; i++)
                begin
                    a = force_div(v[i], m, flg);
                    h = scale_dt(a, dt_q, 17);
                    acc_mem[idx][i] = a;
                    vel_mem[idx][i] = clamp32(vel_mem[idx][i] + h, flg);
                end
            end
        end
        else if (c == CMD_DRIFT) begin
            for (int i = 0; i < 3; i++)
            begin
                h = scale_dt(acc_mem[idx][i], dt_q, 17);
                p = pos_mem[idx][i] + scale_dt(h + vel_mem[idx][i], dt_q, 16);
                if (2 * p >= box_q) p -= box_q;
                else if (2 * p < -box_q) p += box_q;
                pos_mem[idx][i] = clamp32(p, flg);
            end
        end
        if (flg && st == ST_OK) st = ST_SATURATED;
        r.px = pos_mem[idx][0]; r.py = pos_mem[idx][1]; r.pz = pos_mem[idx][2];
        r.vx = vel_mem[idx][0]; r.vy = vel_mem[idx][1]; r.vz = vel_mem[idx][2];
        r.st = st;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        answer_t w;
        if (done) begin
            if (answer_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else begin
                w = answer_q.pop_front();
                if (pos_x !== w.px) report("pos_x", pos_x, w.px);
                if (pos_y !== w.py) report("pos_y", pos_y, w.py);
                if (pos_z !== w.pz) report("pos_z", pos_z, w.pz);
                if (vel_x !== w.vx) report("vel_x", vel_x, w.vx);
                if (vel_y !== w.vy) report("vel_y", vel_y, w.vy);
                if (vel_z !== w.vz) report("vel_z", vel_z, w.vz);
                if (status !== w.st) report("status", status, w.st);
            end
        end
    end

    // one command transfer; gap drawn per item
    task automatic send_cmd(logic [2:0] c, int idx, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic [31:0] m);
        longint v[3];
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        particle_index <= idx[9:0];
        value_x <= x; value_y <= y; value_z <= z;
        particle_mass <= m;
        @(posedge clk iff !busy);
        v[0] = $signed(x); v[1] = $signed(y); v[2] = $signed(z);
        answer_q.push_back(integrate(c, idx, v, m));
        loaded[idx] = 1;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cfg(logic i, logic [31:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= i;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (i == CFG_TIME_STEP) dt_q = d[15:0];
        else box_q = d[30:0];
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535 * 8) - 65535 * 4;
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_index();
        int k;
        k = $urandom_range(0, 1023);
        if ($urandom_range(0, 1)) k = $urandom_range(0, 7);
        return k;
    endfunction

    task automatic test_directed();
        send_cmd(CMD_LOAD_POS, 0, 32'h7fffffff, 32'h80000000, 32'h0, 0);
        send_cmd(CMD_LOAD_POS, 1023, 32'h00010000, 32'hfff00000, 32'h00080000, 0);
        send_cmd(CMD_LOAD_VEL, 1023, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0);
        send_cmd(CMD_FORCE, 1023, 32'h00010000, 32'h1, 32'h1, 0);
        send_cmd(CMD_FORCE, 1023, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'h1);
        send_cmd(CMD_FORCE, 0, 32'h00010000, 32'hffff0000, 32'h0, 32'hffffffff);
        send_cmd(CMD_DRIFT, 1023, 0, 0, 0, 0);
        send_cmd(CMD_DRIFT, 0, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 32'hffffffff, 0, 0, 32'hffffffff);
        send_cmd(3'd5, 1023, 0, 0, 0, 0);
        send_cmd(3'd6, 0, 0, 0, 0, 0);
        send_cmd(3'd7, 0, 0, 0, 0, 0);
        send_cmd(CMD_LOAD_POS, 2, 32'h00070000, 32'hfff90000, 32'h0, 0);
        send_cmd(CMD_LOAD_VEL, 2, 32'h00400000, 32'hffc00000, 32'h0, 0);
        send_cmd(CMD_DRIFT, 2, 0, 0, 0, 0);
    endtask

    task automatic test_config();
        write_cfg(CFG_TIME_STEP, 32'hffff);
        write_cfg(CFG_BOX_SIZE, 32'h7fffffff);
        send_cmd(CMD_FORCE, 2, 32'h7fffffff, 32'h80000000, 32'h1, 32'h10);
        send_cmd(CMD_DRIFT, 2, 0, 0, 0, 0);
        write_cfg(CFG_TIME_STEP, 32'h0);
        write_cfg(CFG_BOX_SIZE, 32'h1);
        send_cmd(CMD_DRIFT, 2, 0, 0, 0, 0);
        send_cmd(CMD_FORCE, 0, 32'h00050000, 32'h3, 32'hffff, 32'h00020000);
    endtask

    task automatic test_random(int n_items);
        int idx;
        logic [2:0] c;
        for (int k = 0; k < n_items; k++)
        begin
            idx = pick_index();
            c = 3'($urandom_range(0, 7));
            if (c > 4 && $urandom_range(0, 3) != 0) c = 3'($urandom_range(0, 4));
            if (!loaded[idx]) c = CMD_LOAD_POS;
            send_cmd(c, idx, rand_word(), rand_word(), rand_word(),
                     ($urandom_range(0, 9) == 0) ? 32'h0 : rand_word());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        write_cfg(CFG_TIME_STEP, 32'd655);
        write_cfg(CFG_BOX_SIZE, 32'd1048576);
        test_random(300);
        write_cfg(CFG_TIME_STEP, $urandom_range(0, 65535));
        write_cfg(CFG_BOX_SIZE, $urandom_range(1, 32'h7fffffff));
        test_random(300);
        write_cfg(CFG_TIME_STEP, 32'd40000);
        write_cfg(CFG_BOX_SIZE, 32'd65536);
        test_random(230);
        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

### velocity_verlet_particle_integrator.f
rtl/core/vvpi_pkg.sv
rtl/core/vvpi_ctrl.sv
rtl/core/vvpi_datapath.sv
rtl/core/velocity_verlet_particle_integrator.sv
verif/tb.sv
